// ===== design/sair_pkg.sv =====
// shared types and constants for the srrip replacement block
// no dependencies
`timescale 1ns / 1ps

package sair_pkg;

	localparam int THRESH_W = 8;
	localparam int SET_IN_W = 11;
	localparam int WAY_IN_W = 4;
	localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 8'd96;

	localparam logic OP_VICTIM = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REDUCE,
		ST_ISSUE,
		ST_CALC,
		ST_WRITE
	} sair_state_t;

	typedef struct packed {
		logic is_update;
		logic hit;
		logic way_ok;
		logic irregular;
	} sair_cmd_t;

endpackage

// ===== design/sair_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sair_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/sair_win_update.sv =====
// outcome window row update: shift in one outcome, keep the miss count
// depends on sair_pkg
`timescale 1ns / 1ps

module sair_win_update #(
	parameter int WINDOW_LEN = 128
) (
	input  logic [WINDOW_LEN+$clog2(WINDOW_LEN)+$clog2(WINDOW_LEN+1)-1:0] row,
	input  sair_pkg::sair_cmd_t                                            cmd,
	input  logic [sair_pkg::THRESH_W-1:0]                                  threshold,
	output logic [WINDOW_LEN+$clog2(WINDOW_LEN)+$clog2(WINDOW_LEN+1)-1:0] new_row,
	output logic                                                           irregular
);
	import sair_pkg::*;

	localparam int POS_W = $clog2(WINDOW_LEN);
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;

	logic [WINDOW_LEN-1:0] bits, new_bits;
	logic [POS_W-1:0]      pos, new_pos;
	logic [CNT_W-1:0]      cnt, new_cnt, cnt_sel;
	logic                  old_bit, miss_bit;

	always_comb begin
		bits     = row[WINDOW_LEN-1:0];
		pos      = row[WINDOW_LEN +: POS_W];
		cnt      = row[WINDOW_LEN+POS_W +: CNT_W];
		miss_bit = ~cmd.hit;
		old_bit  = bits[pos];
		new_cnt  = cnt - CNT_W'(old_bit) + CNT_W'(miss_bit);
		new_bits = bits;
		new_bits[pos] = miss_bit;
		new_pos  = (pos == POS_W'(WINDOW_LEN - 1)) ? '0 : pos + 1'b1;
		new_row  = {new_cnt, new_pos, new_bits};
		cnt_sel  = cmd.is_update ? new_cnt : cnt;
		irregular = CMP_W'(cnt_sel) > CMP_W'(threshold);
	end

endmodule

// ===== design/sair_rrv_update.sv =====
// re-reference row logic: oldest value, victim search, aging and insertion
// depends on sair_pkg
`timescale 1ns / 1ps

module sair_rrv_update #(
	parameter int NUM_WAYS  = 16,
	parameter int MAX_VALUE = 3
) (
	input  logic [NUM_WAYS*$clog2(MAX_VALUE+1)-1:0] row,
	input  logic [$clog2(MAX_VALUE+1)-1:0]          top_in,
	input  sair_pkg::sair_cmd_t                     cmd,
	input  logic [$clog2(NUM_WAYS)-1:0]             way_sel,
	output logic [$clog2(MAX_VALUE+1)-1:0]          top,
	output logic [$clog2(NUM_WAYS)-1:0]             victim,
	output logic [NUM_WAYS*$clog2(MAX_VALUE+1)-1:0] new_row
);
	import sair_pkg::*;

	localparam int VAL_W = $clog2(MAX_VALUE + 1);
	localparam int WAY_W = $clog2(NUM_WAYS);

	logic [MAX_VALUE:0]              present;
	logic [VAL_W-1:0]                lift, ins_val;
	logic [NUM_WAYS*VAL_W-1:0]       aged_row, upd_row;

	// highest value present in the row
	always_comb begin
		present = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			for (int v = 0; v <= MAX_VALUE; v++) begin
				if (row[w*VAL_W +: VAL_W] == VAL_W'(v)) begin
					present[v] = 1'b1;
				end
			end
		end
		top = '0;
		for (int v = 0; v <= MAX_VALUE; v++) begin
			if (present[v]) begin
				top = VAL_W'(v);
			end
		end
	end

	always_comb begin
		lift   = VAL_W'(MAX_VALUE) - top_in;
		victim = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (row[w*VAL_W +: VAL_W] == top_in) begin
				victim = WAY_W'(w);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[w*VAL_W +: VAL_W] = row[w*VAL_W +: VAL_W] + lift;
		end
		if (cmd.hit) begin
			ins_val = '0;
		end else if (cmd.irregular) begin
			ins_val = VAL_W'(MAX_VALUE);
		end else begin
			ins_val = VAL_W'(MAX_VALUE - 1);
		end
		upd_row = row;
		if (cmd.way_ok) begin
			upd_row[way_sel*VAL_W +: VAL_W] = ins_val;
		end
		new_row = cmd.is_update ? upd_row : aged_row;
	end

endmodule

// ===== design/srrip_adaptive_insertion_replacement.sv =====
// top level of the srrip replacement block with adaptive insertion
// depends on sair_pkg, sair_ram, sair_win_update, sair_rrv_update
//
//   channel | handshake            | word
//   --------+----------------------+----------------------------------------
//   in      | in_valid / in_stall  | opcode, set_index, way_index, hit
//   out     | out_valid / out_stall| victim_way, irregular
//   cfg     | cfg_valid / cfg_ready| miss_threshold
//
// an item passes accept, ram read, row compute and write back, taking no new item
// meanwhile; the single read-modify-write of the per-set rows in the two rams sets this.
// when NUM_SETS is below 2048 and not a power of two, a set reduction comes
// before the ram read, one compare and subtract per cycle.
// after reset a clearing pass writes all NUM_SETS rows of both rams; no item is
// taken meanwhile, configuration writes are.
// a stalled output holds the write back until the output register frees.
`timescale 1ns / 1ps

module srrip_adaptive_insertion_replacement #(
	parameter int NUM_SETS   = 2048,
	parameter int NUM_WAYS   = 16,
	parameter int WINDOW_LEN = 128,
	parameter int MAX_VALUE  = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            opcode,
	input  logic [sair_pkg::SET_IN_W-1:0]   set_index,
	input  logic [sair_pkg::WAY_IN_W-1:0]   way_index,
	input  logic                            hit,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sair_pkg::WAY_IN_W-1:0]   victim_way,
	output logic                            irregular,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sair_pkg::THRESH_W-1:0]   miss_threshold
);
	import sair_pkg::*;

	localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W   = $clog2(NUM_WAYS);
	localparam int VAL_W   = $clog2(MAX_VALUE + 1);
	localparam int RRV_W   = NUM_WAYS * VAL_W;
	localparam int WIN_W   = WINDOW_LEN + $clog2(WINDOW_LEN) + $clog2(WINDOW_LEN + 1);
	localparam int RED_W   = SET_IN_W + 17;
	localparam bit NEED_REDUCE = (NUM_SETS < (1 << SET_IN_W)) &&
		((NUM_SETS & (NUM_SETS - 1)) != 0);

	sair_state_t state_q, state_d;

	logic [THRESH_W-1:0] thresh_q;
	logic                opcode_q, hit_q;
	logic [SET_IN_W-1:0] set_q;
	logic [WAY_IN_W-1:0] way_q;
	logic [3:0]          red_k_q;
	logic [SET_W-1:0]    clr_q;
	logic [VAL_W-1:0]    top_q;
	logic                irr_q;
	logic [WIN_W-1:0]    win_row_q;
	logic                out_valid_q, irregular_q;
	logic [WAY_IN_W-1:0] victim_way_q;

	logic accept, rd_en, wr_go, out_load;
	logic rrv_we, win_we;
	logic [SET_W-1:0] set_addr, waddr;
	logic [SET_W+SET_IN_W-1:0] set_ext;
	logic [WAY_W+WAY_IN_W-1:0] way_ext, vict_ext;
	logic [WAY_W-1:0] way_sel, victim;
	logic [RED_W-1:0] red_val, red_div;
	logic [RRV_W-1:0] rrv_rdata, rrv_wdata, rrv_new;
	logic [WIN_W-1:0] win_rdata, win_wdata, win_new;
	logic [VAL_W-1:0] top;
	logic             irr_calc;
	sair_cmd_t        cmd;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign victim_way = victim_way_q;
	assign irregular  = irregular_q;

	assign set_ext  = {{SET_W{1'b0}}, set_q};
	assign set_addr = (NUM_SETS == 1) ? '0 : set_ext[SET_W-1:0];
	assign way_ext  = {{WAY_W{1'b0}}, way_q};
	assign way_sel  = way_ext[WAY_W-1:0];
	assign red_val  = RED_W'(set_q);
	assign red_div  = RED_W'(NUM_SETS) << red_k_q;

	assign cmd.is_update = (opcode_q == OP_UPDATE);
	assign cmd.hit       = hit_q;
	assign cmd.way_ok    = way_ext < (WAY_W + WAY_IN_W)'(NUM_WAYS);
	assign cmd.irregular = irr_q;

	assign wr_go   = !out_valid_q || !out_stall;
	assign waddr   = (state_q == ST_CLEAR) ? clr_q : set_addr;
	assign rrv_wdata = (state_q == ST_CLEAR) ? {NUM_WAYS{VAL_W'(MAX_VALUE)}} : rrv_new;
	assign win_wdata = (state_q == ST_CLEAR) ? '0 : win_row_q;
	assign vict_ext  = {{WAY_IN_W{1'b0}}, victim};

	always_comb begin
		state_d  = state_q;
		rd_en    = 1'b0;
		rrv_we   = 1'b0;
		win_we   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				rrv_we = 1'b1;
				win_we = 1'b1;
				if (clr_q == SET_W'(NUM_SETS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = NEED_REDUCE ? ST_REDUCE : ST_ISSUE;
				end
			end
			ST_REDUCE: begin
				if (red_k_q == '0) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				rd_en   = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (wr_go) begin
					out_load = 1'b1;
					rrv_we   = !cmd.is_update || cmd.way_ok;
					win_we   = cmd.is_update;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			thresh_q    <= THRESHOLD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				thresh_q <= miss_threshold;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_q <= opcode;
			set_q    <= set_index;
			way_q    <= way_index;
			hit_q    <= hit;
			red_k_q  <= 4'(SET_IN_W - 1);
		end
		if (state_q == ST_REDUCE) begin
			if (red_val >= red_div) begin
				set_q <= SET_IN_W'(red_val - red_div);
			end
			red_k_q <= red_k_q - 1'b1;
		end
		if (state_q == ST_CALC) begin
			top_q     <= top;
			irr_q     <= irr_calc;
			win_row_q <= win_new;
		end
		if (out_load) begin
			victim_way_q <= cmd.is_update ? '0 : vict_ext[WAY_IN_W-1:0];
			irregular_q  <= irr_q;
		end
	end

	sair_ram #(.WIDTH(RRV_W), .DEPTH(NUM_SETS)) u_rrv_ram (
		.clk   (clk),
		.we    (rrv_we),
		.waddr (waddr),
		.wdata (rrv_wdata),
		.re    (rd_en),
		.raddr (set_addr),
		.rdata (rrv_rdata)
	);

	sair_ram #(.WIDTH(WIN_W), .DEPTH(NUM_SETS)) u_win_ram (
		.clk   (clk),
		.we    (win_we),
		.waddr (waddr),
		.wdata (win_wdata),
		.re    (rd_en),
		.raddr (set_addr),
		.rdata (win_rdata)
	);

	sair_win_update #(.WINDOW_LEN(WINDOW_LEN)) u_win_update (
		.row       (win_rdata),
		.cmd       (cmd),
		.threshold (thresh_q),
		.new_row   (win_new),
		.irregular (irr_calc)
	);

	sair_rrv_update #(.NUM_WAYS(NUM_WAYS), .MAX_VALUE(MAX_VALUE)) u_rrv_update (
		.row     (rrv_rdata),
		.top_in  (top_q),
		.cmd     (cmd),
		.way_sel (way_sel),
		.top     (top),
		.victim  (victim),
		.new_row (rrv_new)
	);

endmodule

// ===== design/sair_checker.sv =====
// port-level checks for the srrip replacement block, bound to the top level
// depends on sair_pkg and srrip_adaptive_insertion_replacement
`timescale 1ns / 1ps

module sair_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [sair_pkg::WAY_IN_W-1:0] victim_way,
	input logic                          irregular
);
	import sair_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(victim_way) && $stable(irregular))
		else $error("stalled result word changed");

	// an accepted word keeps the input stalled through read, compute and write back
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
		else $error("input taken while a word is in flight");

	// a result only appears out of write back, never from idle
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a word in flight");

endmodule

bind srrip_adaptive_insertion_replacement sair_checker u_sair_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.victim_way (victim_way),
	.irregular  (irregular)
);

// ===== dv/tb.sv =====
// testbench for srrip_adaptive_insertion_replacement: directed and random words checked
// against an in-bench srrip predictor, with random idling and one long output hold-off
// depends on sair_pkg and the design sources
`timescale 1ns / 1ps

module tb;

	localparam int NSETS     = 2048;
	localparam int NWAYS     = 16;
	localparam logic [1:0] RRV_MAX = 2'd3;
	localparam int LIMIT     = 500000;

	typedef struct packed {
		logic [3:0] victim_way;
		logic       irregular;
	} srrip_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic opcode = 1'b0;
	logic [sair_pkg::SET_IN_W-1:0] set_index = '0;
	logic [sair_pkg::WAY_IN_W-1:0] way_index = '0;
	logic hit = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [sair_pkg::WAY_IN_W-1:0] victim_way;
	logic irregular;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [sair_pkg::THRESH_W-1:0] cfg_thresh = '0;

	// predictor state
	logic [1:0] rrv_model [NSETS][NWAYS];
	logic [127:0] outcome_bits [NSETS];
	logic [6:0] win_pos_model [NSETS];
	logic [7:0] miss_cnt_model [NSETS];
	logic [7:0] thresh_model;

	srrip_result_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit idling = 1'b1;
	int hold_ask = 0;
	int hold_left = 0;
	int stall_left = 0;
	logic [10:0] hot_sets [4];

	always #4 clk = ~clk;

	srrip_adaptive_insertion_replacement i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.set_index(set_index),
		.way_index(way_index),
		.hit(hit),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.victim_way(victim_way),
		.irregular(irregular),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.miss_threshold(cfg_thresh)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic reset_model();
		int s;
		int w;
		for (s = 0; s < NSETS; s++) begin
			for (w = 0; w < NWAYS; w++) rrv_model[s][w] = RRV_MAX;
			outcome_bits[s] = '0;
			win_pos_model[s] = '0;
			miss_cnt_model[s] = '0;
		end
		thresh_model = sair_pkg::THRESHOLD_RESET;
	endtask

	task automatic predict_srrip(input logic op, input logic [10:0] s, input logic [3:0] w,
			input logic h, output srrip_result_t r);
		int i;
		logic [1:0] top;
		logic [1:0] lift;
		logic found;
		logic [6:0] p;
		logic b;
		r.victim_way = '0;
		if (op == sair_pkg::OP_VICTIM) begin
			top = '0;
			for (i = 0; i < NWAYS; i++)
				if (rrv_model[s][i] > top) top = rrv_model[s][i];
			lift = RRV_MAX - top;
			found = 1'b0;
			for (i = 0; i < NWAYS; i++) begin
				rrv_model[s][i] = rrv_model[s][i] + lift;
				if (!found && rrv_model[s][i] == RRV_MAX) begin
					found = 1'b1;
					r.victim_way = i[3:0];
				end
			end
		end else begin
			p = win_pos_model[s];
			b = ~h;
			miss_cnt_model[s] = miss_cnt_model[s] - {7'd0, outcome_bits[s][p]} + {7'd0, b};
			outcome_bits[s][p] = b;
			win_pos_model[s] = p + 7'd1;
			if (h)
				rrv_model[s][w] = 2'd0;
			else if (miss_cnt_model[s] > thresh_model)
				rrv_model[s][w] = RRV_MAX;
			else
				rrv_model[s][w] = RRV_MAX - 2'd1;
		end
		r.irregular = miss_cnt_model[s] > thresh_model;
	endtask

	// sends one word; called right after a rising edge
	task automatic send_word(input logic op, input logic [10:0] s, input logic [3:0] w,
			input logic h);
		int gap;
		srrip_result_t r;
		gap = idling ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		set_index <= s;
		way_index <= w;
		hit <= h;
		do @(posedge clk); while (in_stall);
		predict_srrip(op, s, w, h, r);
		pending_results.push_back(r);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_thresh <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thresh_model = v;
	endtask

	task automatic send_random(input int n, input int miss_pct);
		int k;
		logic op;
		logic [10:0] s;
		for (k = 0; k < n; k++) begin
			op = ($urandom_range(0, 99) < 30) ? sair_pkg::OP_VICTIM : sair_pkg::OP_UPDATE;
			if ($urandom_range(0, 99) < 85)
				s = hot_sets[$urandom_range(0, 3)];
			else
				s = 11'($urandom_range(0, NSETS - 1));
			send_word(op, s, 4'($urandom_range(0, 15)), $urandom_range(0, 99) >= miss_pct);
		end
	endtask

	task automatic test_reset_state();
		send_word(sair_pkg::OP_VICTIM, 11'd0, 4'd15, 1'b1);
		send_word(sair_pkg::OP_VICTIM, 11'd2047, 4'd0, 1'b0);
		send_word(sair_pkg::OP_UPDATE, 11'd0, 4'd0, 1'b1);
		send_word(sair_pkg::OP_VICTIM, 11'd0, 4'd0, 1'b0);
		send_word(sair_pkg::OP_UPDATE, 11'd0, 4'd15, 1'b0);
		send_word(sair_pkg::OP_UPDATE, 11'd2047, 4'd15, 1'b1);
		send_word(sair_pkg::OP_VICTIM, 11'd2047, 4'd15, 1'b1);
		send_word(sair_pkg::OP_VICTIM, 11'd1024, 4'd0, 1'b0);
		drain();
	endtask

	task automatic test_aging();
		int w;
		write_threshold(8'd255);
		for (w = 0; w < NWAYS - 1; w++)
			send_word(sair_pkg::OP_UPDATE, 11'd1365, w[3:0], 1'b1);
		send_word(sair_pkg::OP_UPDATE, 11'd1365, 4'd15, 1'b0);
		send_word(sair_pkg::OP_VICTIM, 11'd1365, 4'd0, 1'b0);
		drain();
	endtask

	task automatic test_threshold_sweep();
		write_threshold(8'd96);
		send_random(150, 90);
		drain();
		write_threshold(8'd128);
		send_random(120, 95);
		drain();
		write_threshold(8'd0);
		idling = 1'b0;
		send_random(120, 50);
		drain();
		idling = 1'b1;
		write_threshold(8'd64);
		send_random(130, 70);
		drain();
		write_threshold(8'd1);
		send_random(100, 30);
		drain();
		write_threshold(8'd127);
		send_random(80, 85);
		drain();
		write_threshold(8'($urandom_range(0, 255)));
		send_random(140, 60);
		drain();
	endtask

	task automatic test_backpressure();
		write_threshold(8'd100);
		idling = 1'b0;
		hold_ask = 300;
		send_random(86, 80);
		drain();
		idling = 1'b1;
	endtask

	// output stall
	always @(posedge clk) begin
		if (hold_ask > 0) begin
			hold_left = hold_ask;
			hold_ask = 0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (idling && $urandom_range(0, 99) < 25) stall_left = pick_gap();
		end
	end

	// result check
	always @(posedge clk) begin
		srrip_result_t exp_word;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word victim_way=%0d irregular=%0d",
					$time, victim_way, irregular);
				errors++;
			end else begin
				exp_word = pending_results.pop_front();
				if (victim_way !== exp_word.victim_way) begin
					$display("%0t: victim_way expected %0d actual %0d",
						$time, exp_word.victim_way, victim_way);
					errors++;
				end
				if (irregular !== exp_word.irregular) begin
					$display("%0t: irregular expected %0d actual %0d",
						$time, exp_word.irregular, irregular);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("srrip_adaptive_insertion_replacement test failed");
			$finish;
		end
	end

	initial begin
		reset_model();
		hot_sets[0] = 11'd0;
		hot_sets[1] = 11'd2047;
		hot_sets[2] = 11'($urandom_range(1, NSETS - 2));
		hot_sets[3] = 11'($urandom_range(1, NSETS - 2));
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_aging();
		test_threshold_sweep();
		test_backpressure();
		if (pending_results.size() != 0) errors++;
		if (errors == 0) begin
			$display("srrip_adaptive_insertion_replacement test passed");
		end else begin
			$display("srrip_adaptive_insertion_replacement test failed");
		end
		$finish;
	end

endmodule
